// ===== rtl/polygon_face_normal_core_assert.svh =====
// assertion macros shared by the checker
`ifndef POLYGON_FACE_NORMAL_CORE_ASSERT_SVH
`define POLYGON_FACE_NORMAL_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define PFN_ASSERT_NOW(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("pfn check failed");

// pre at one edge implies post at the next
`define PFN_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("pfn check failed");

`endif

// ===== rtl/pfn_pkg.sv =====
package pfn_pkg;
    localparam int PFN_MAX_VERTICES = 256;
    localparam int PFN_COORD_W      = 24;
    localparam int PFN_TAG_W        = 16;
    localparam int PFN_NORM_W       = 16;
    localparam int PFN_SUM_W        = 60;
    localparam int PFN_MUL_W        = 32;
    localparam int PFN_IN_W         = 88;
    localparam int PFN_OUT_W        = 72;
endpackage

// ===== rtl/pfn_mul.sv =====
module pfn_mul
    import pfn_pkg::*;
(
    input  logic                          clk,
    input  logic signed [PFN_MUL_W-1:0]   a,
    input  logic signed [PFN_MUL_W-1:0]   b,
    output logic signed [2*PFN_MUL_W-1:0] p
);

    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

// ===== rtl/polygon_face_normal_core.sv =====
// channel  dir  signals                  content
// s_axis   in   s_tvalid/s_tready        one vertex per transfer, s_tlast ends the face
// m_axis   out  m_tvalid/m_tready        one unit normal per face
//
// a vertex is accepted and then takes its edge term on the shared multiplier,
// the first vertex of a face is only accepted
// the last vertex adds the closing edge, the magnitude steps, the normalising shifts,
// the square steps, the root steps and a divide per axis, then the output step
// s_tready is high only while the sequencer is idle
// a finished normal waits in the output register, more vertices are still taken
// rst_n clears the sequencer, the open face and the output valid
module polygon_face_normal_core
    import pfn_pkg::*;
#(
    parameter int MAX_VERTICES = PFN_MAX_VERTICES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PFN_IN_W-1:0]  s_tdata,  // vertex_x, vertex_y, vertex_z, face_tag
    input  logic                 s_tlast,  // is_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PFN_OUT_W-1:0] m_tdata   // result_tag, normal_x, normal_y, normal_z,
                                           // degenerate, too_long, zero fill
);

    localparam int CW = $clog2(MAX_VERTICES + 2);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EDGE = 4'd1;
    localparam logic [3:0] ST_MAG  = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_DINI = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0]                    state_reg;
    logic [4:0]                    cnt_reg;
    logic [1:0]                    k_reg;
    logic signed [PFN_COORD_W-1:0] v_reg [3];
    logic signed [PFN_COORD_W-1:0] prev_reg [3];
    logic signed [PFN_COORD_W-1:0] first_reg [3];
    logic [PFN_SUM_W-1:0]          sum_reg [3];
    logic [PFN_SUM_W-1:0]          mags_reg [3];
    logic                          neg_reg [3];
    logic [PFN_SUM_W-1:0]          max_reg;
    logic [CW-1:0]                 count_reg;
    logic                          in_face_reg;
    logic                          last_reg;
    logic                          close_reg;
    logic [PFN_TAG_W-1:0]          tag_reg;
    logic [61:0]                   sq_reg;
    logic [63:0]                   rv_reg;
    logic [63:0]                   res_reg;
    logic [62:0]                   bit_reg;
    logic [46:0]                   rem_reg;
    logic [47:0]                   dsh_reg;
    logic [15:0]                   q_reg;
    logic [PFN_NORM_W-1:0]         norm_reg [3];
    logic                          deg_reg;
    logic                          out_valid_reg;
    logic [PFN_OUT_W-1:0]          out_data_reg;

    logic signed [PFN_COORD_W-1:0] ea [3];
    logic signed [PFN_COORD_W-1:0] eb [3];
    logic signed [PFN_COORD_W:0]   ed;
    logic signed [PFN_COORD_W:0]   es;
    logic signed [PFN_MUL_W-1:0]   mul_a;
    logic signed [PFN_MUL_W-1:0]   mul_b;
    logic signed [2*PFN_MUL_W-1:0] mul_p;
    logic [1:0]                    acc_idx;
    logic [PFN_SUM_W-1:0]          abs_val;
    logic [63:0]                   sqrt_t;
    logic [15:0]                   q_next;
    logic signed [PFN_COORD_W-1:0] in_v [3];

    assign in_v[0] = s_tdata[23:0];
    assign in_v[1] = s_tdata[47:24];
    assign in_v[2] = s_tdata[71:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign acc_idx  = cnt_reg[1:0] - 2'd1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = close_reg ? v_reg[i] : prev_reg[i];
            eb[i] = close_reg ? first_reg[i] : v_reg[i];
        end
    end

    always_comb
    begin
        ed = '0;
        es = '0;
        case (cnt_reg[1:0])
            2'd0:
            begin
                ed = {eb[1][23], eb[1]} - {ea[1][23], ea[1]};
                es = {ea[2][23], ea[2]} + {eb[2][23], eb[2]};
            end
            2'd1:
            begin
                ed = {eb[2][23], eb[2]} - {ea[2][23], ea[2]};
                es = {ea[0][23], ea[0]} + {eb[0][23], eb[0]};
            end
            2'd2:
            begin
                ed = {eb[0][23], eb[0]} - {ea[0][23], ea[0]};
                es = {ea[1][23], ea[1]} + {eb[1][23], eb[1]};
            end
            default:
            begin
                ed = '0;
                es = '0;
            end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_EDGE:
            begin
                mul_a = PFN_MUL_W'(ed);
                mul_b = PFN_MUL_W'(es);
            end
            ST_SQ:
            begin
                if (cnt_reg[1:0] != 2'd3)
                begin
                    mul_a = {2'b00, mags_reg[cnt_reg[1:0]][29:0]};
                    mul_b = {2'b00, mags_reg[cnt_reg[1:0]][29:0]};
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pfn_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_comb
    begin
        abs_val = '0;
        if (cnt_reg[1:0] != 2'd3)
        begin
            abs_val = sum_reg[cnt_reg[1:0]][PFN_SUM_W-1] ?
                      (PFN_SUM_W'(0) - sum_reg[cnt_reg[1:0]]) : sum_reg[cnt_reg[1:0]];
        end
    end

    assign sqrt_t = res_reg + {1'b0, bit_reg};
    assign q_next = {q_reg[14:0], ({1'b0, rem_reg} >= dsh_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            in_face_reg   <= 1'b0;
            count_reg     <= '0;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            v_reg[i] <= in_v[i];
                        end
                        tag_reg  <= s_tdata[87:72];
                        last_reg <= s_tlast;
                        cnt_reg  <= '0;
                        if (!in_face_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                first_reg[i] <= in_v[i];
                                prev_reg[i]  <= in_v[i];
                                sum_reg[i]   <= '0;
                            end
                            count_reg   <= CW'(1);
                            in_face_reg <= 1'b1;
                            close_reg   <= s_tlast;
                            state_reg   <= s_tlast ? ST_EDGE : ST_IDLE;
                        end
                        else
                        begin
                            if (count_reg <= CW'(MAX_VERTICES))
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            close_reg <= 1'b0;
                            state_reg <= ST_EDGE;
                        end
                    end
                end
                ST_EDGE:
                begin
                    if (cnt_reg[1:0] != 2'd0)
                    begin
                        sum_reg[acc_idx] <= sum_reg[acc_idx] + mul_p[PFN_SUM_W-1:0];
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        cnt_reg <= '0;
                        if (close_reg)
                        begin
                            in_face_reg <= 1'b0;
                            state_reg   <= ST_MAG;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                prev_reg[i] <= v_reg[i];
                            end
                            if (last_reg)
                            begin
                                close_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_MAG:
                begin
                    mags_reg[cnt_reg[1:0]] <= abs_val;
                    neg_reg[cnt_reg[1:0]]  <= sum_reg[cnt_reg[1:0]][PFN_SUM_W-1];
                    if (cnt_reg[1:0] == 2'd0 || abs_val > max_reg)
                    begin
                        max_reg <= abs_val;
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[1:0] == 2'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (max_reg == '0)
                    begin
                        deg_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            norm_reg[i] <= '0;
                        end
                        state_reg <= ST_OUT;
                    end
                    else if (max_reg >= (PFN_SUM_W'(1) << 30))
                    begin
                        max_reg <= max_reg >> 1;
                        for (int i = 0; i < 3; i++)
                        begin
                            mags_reg[i] <= mags_reg[i] >> 1;
                        end
                    end
                    else if (max_reg < (PFN_SUM_W'(1) << 29))
                    begin
                        max_reg <= max_reg << 1;
                        for (int i = 0; i < 3; i++)
                        begin
                            mags_reg[i] <= mags_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        deg_reg   <= 1'b0;
                        sq_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (cnt_reg[1:0] != 2'd0)
                    begin
                        sq_reg <= sq_reg + mul_p[61:0];
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        rv_reg    <= {2'b00, sq_reg + mul_p[61:0]};
                        res_reg   <= '0;
                        bit_reg   <= 63'd1 << 62;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (rv_reg >= sqrt_t)
                    begin
                        rv_reg  <= rv_reg - sqrt_t;
                        res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DINI;
                    end
                end
                ST_DINI:
                begin
                    rem_reg   <= {mags_reg[k_reg][31:0], 15'd0} + {15'd0, res_reg[31:0]};
                    dsh_reg   <= {res_reg[31:0], 16'd0};
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if ({1'b0, rem_reg} >= dsh_reg)
                    begin
                        rem_reg <= 47'(({1'b0, rem_reg} - dsh_reg));
                    end
                    dsh_reg <= dsh_reg >> 1;
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        norm_reg[k_reg] <= neg_reg[k_reg] ? (16'd0 - q_next) : q_next;
                        k_reg           <= k_reg + 2'd1;
                        state_reg       <= (k_reg == 2'd2) ? ST_OUT : ST_DINI;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {6'd0, (count_reg > CW'(MAX_VERTICES)), deg_reg,
                                          norm_reg[2], norm_reg[1], norm_reg[0], tag_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pfn_checker.sv =====
`include "polygon_face_normal_core_assert.svh"

module pfn_checker
    import pfn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [PFN_OUT_W-1:0] m_tdata
);

    `PFN_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `PFN_ASSERT_NEXT(a_busy_after_last, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready)
    `PFN_ASSERT_NOW(a_degenerate_zero, clk, rst_n, !(m_tvalid && m_tdata[64]) || m_tdata[63:16] == 48'd0)
    `PFN_ASSERT_NEXT(a_no_early_result, clk, rst_n, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid)

endmodule

bind polygon_face_normal_core pfn_checker u_pfn_checker (.*);
